[hw/rtl/ltpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltpg_pkg
// Shared types, constants and helper functions of the twinkle pixel generator.
// ----------------------------------------------------------------------------
package ltpg_pkg;

    localparam int TIME_W  = 32;
    localparam int LCG_W   = 16;
    localparam int MULT_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 4;
    localparam int SHIFT_W = 4;

    localparam logic [LCG_W-1:0] LCG_SEED    = 16'd11337;
    localparam logic [LCG_W-1:0] LCG_MUL     = 16'd2053;
    localparam logic [LCG_W-1:0] LCG_ADD     = 16'd1384;
    // two steps folded into one: x*2053^2 + (1384*2053 + 1384), mod 2^16
    localparam logic [LCG_W-1:0] LCG_MUL2    = 16'd20505;
    localparam logic [LCG_W-1:0] LCG_ADD2    = 16'd24688;

    localparam logic [CFG_W-1:0] CFG_MAX       = 4'd8;
    localparam logic [CFG_W-1:0] DENSITY_RESET = 4'd8;
    localparam logic [CFG_W-1:0] SPEED_RESET   = 4'd5;
    localparam logic [SHIFT_W-1:0] SHIFT_BASE  = 4'd8;

    localparam logic [IDX_W-1:0] REG_DENSITY = 4'd0;
    localparam logic [IDX_W-1:0] REG_SPEED   = 4'd1;

    localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;
    localparam logic [MULT_W-1:0] MULT_BASE   = 5'h08;
    localparam logic [BYTE_W-1:0] GATE_MASK   = 8'h0E;
    localparam logic [BYTE_W-1:0] WAVE_KNEE   = 8'd86;
    localparam logic [BYTE_W-1:0] WAVE_TOP    = 8'd255;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // one pixel after the generator, waiting for the clock math
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [MULT_W-1:0] mult;
        logic [LCG_W-1:0]  offset;
        logic [BYTE_W-1:0] salt;
    } t_job;

    // fast attack, slow decay
    function automatic logic [BYTE_W-1:0] attack_decay(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] k;
        logic [BYTE_W:0]   up;
        logic [BYTE_W:0]   down;
        k    = v - WAVE_KNEE;
        up   = {1'b0, v} + {v, 1'b0};
        down = {1'b0, k} + {2'b00, k[BYTE_W-1:1]};
        if (v < WAVE_KNEE) begin
            attack_decay = up[BYTE_W-1:0];
        end else begin
            attack_decay = WAVE_TOP - down[BYTE_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/ltpg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltpg_front
// Accepts pixel requests, steps the generator twice and derives offset,
// speed multiplier and salt for the back end.
// ----------------------------------------------------------------------------
module ltpg_front
    import ltpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TIME_W-1:0] i_time_ms,
    input  logic              i_frame_start,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job
);

    logic [LCG_W-1:0]  r_lcg;
    logic [LCG_W-1:0]  n_lcg;
    logic [LCG_W-1:0]  base;
    logic [LCG_W-1:0]  offset;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] nib_sum;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign base   = i_frame_start ? LCG_SEED : r_lcg;
    assign offset = base * LCG_MUL + LCG_ADD;
    assign n_lcg  = base * LCG_MUL2 + LCG_ADD2;

    assign lo      = n_lcg[BYTE_W-1:0];
    assign nib_sum = ((lo >> 4) + (lo & NIBBLE_MASK)) & NIBBLE_MASK;

    always_comb begin
        o_job.time_ms = i_time_ms;
        o_job.mult    = nib_sum[MULT_W-1:0] + MULT_BASE;
        o_job.offset  = offset;
        o_job.salt    = n_lcg[LCG_W-1:BYTE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= LCG_SEED;
        end else if (o_push) begin
            r_lcg <= n_lcg;
        end
    end

endmodule

[hw/rtl/ltpg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltpg_queue
// Two-entry queue between the generator front end and the clock back end.
// ----------------------------------------------------------------------------
module ltpg_queue
    import ltpg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_wdata,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_rdata
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/ltpg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltpg_back
// Scales the frame time, applies offset and speed shift, gates on density
// and shapes the brightness wave. Two stages, output register at the end.
// ----------------------------------------------------------------------------
module ltpg_back
    import ltpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    input  t_job              i_job,
    input  logic [CFG_W-1:0]  i_density,
    input  logic [CFG_W-1:0]  i_speed,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_pixel_hue,
    output logic [BYTE_W-1:0] o_pixel_brightness
);

    // stage 1: product
    logic              r_s1_valid;
    logic [TIME_W-1:0] r_s1_prod;
    logic [LCG_W-1:0]  r_s1_offset;
    logic [BYTE_W-1:0] r_s1_salt;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_hue;
    logic [BYTE_W-1:0] r_bright;

    logic              out_load;
    logic              s1_load;
    logic [TIME_W-1:0] pix_clk;
    logic [TIME_W-1:0] shifted;
    logic [SHIFT_W-1:0] shift;
    logic [BYTE_W-1:0] fast;
    logic [BYTE_W-1:0] slow;
    logic              lit;

    assign out_load  = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_load   = !r_s1_valid || out_load;
    assign o_job_pop = s1_load && i_job_valid;

    assign pix_clk = (r_s1_prod >> 3) + TIME_W'(r_s1_offset);
    assign shift   = SHIFT_BASE - i_speed;
    assign shifted = pix_clk >> shift;
    assign fast    = shifted[BYTE_W-1:0];
    assign slow    = shifted[LCG_W-1:BYTE_W] ^ r_s1_salt;
    assign lit     = (slow & GATE_MASK) < {4'b0000, i_density};

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1_prod   <= i_job.time_ms * TIME_W'(i_job.mult);
            r_s1_offset <= i_job.offset;
            r_s1_salt   <= i_job.salt;
        end
        if (out_load) begin
            r_hue    <= {slow[3:0], 4'b0000} + r_s1_salt;
            r_bright <= lit ? attack_decay(fast) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_job_valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_pixel_hue        = r_hue;
    assign o_pixel_brightness = r_bright;

endmodule

[hw/rtl/led_twinkle_pixel_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_twinkle_pixel_generator_unit
// Twinkle pattern generator: one hue and brightness byte pair per pixel.
// ----------------------------------------------------------------------------
// A request goes through the queue, the stage-1 product register and the
// output register. One pixel per cycle while i_ready is high; the generator
// step is combinational and the 32x5 time multiply is registered in stage 1.
// Reset (synchronous, active low): generator seed 11337, density 8, speed 5,
// queue and pipeline emptied. Config port is always ready.
module led_twinkle_pixel_generator_unit
    import ltpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TIME_W-1:0] i_time_ms,
    input  logic              i_frame_start,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_pixel_hue,
    output logic [BYTE_W-1:0] o_pixel_brightness,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [CFG_W-1:0] r_density;
    logic [CFG_W-1:0] r_speed;
    logic             cfg_ok;

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_job front_job;
    t_job q_job;

    assign o_cfg_ready = 1'b1;
    // out-of-range values leave the register untouched
    assign cfg_ok = i_cfg_valid && (i_cfg_data <= CFG_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= DENSITY_RESET;
            r_speed   <= SPEED_RESET;
        end else if (cfg_ok) begin
            if (i_cfg_index == REG_DENSITY) begin
                r_density <= i_cfg_data;
            end else if (i_cfg_index == REG_SPEED) begin
                r_speed <= i_cfg_data;
            end
        end
    end

    ltpg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_time_ms     (i_time_ms),
        .i_frame_start (i_frame_start),
        .i_full        (full),
        .o_push        (push),
        .o_job         (front_job)
    );

    ltpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_rdata (q_job)
    );

    ltpg_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job_valid        (q_valid),
        .o_job_pop          (pop),
        .i_job              (q_job),
        .i_density          (r_density),
        .i_speed            (r_speed),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_pixel_hue        (o_pixel_hue),
        .o_pixel_brightness (o_pixel_brightness)
    );

endmodule
